### hdl/qti_pkg.sv
// Package with the shared types, widths and codes of the six-node triangle interpolator.
package qti_pkg;

  localparam int COORD_W = 16;
  localparam int NODE_W  = 24;
  localparam int RES_W   = 32;
  localparam int NODES   = 6;

  // Extended coordinates: w = 1 - u - v needs two bits more than u and v.
  localparam int EXT_W   = COORD_W + 2;
  // Basis weights (value weights reach about 2^34 in magnitude).
  localparam int WGT_W   = 36;
  localparam int PROD_W  = NODE_W + WGT_W;
  localparam int ACC_W   = 64;

  // Q2.14 unit and the two rounding shifts.
  localparam int ONE_Q14     = 16384;
  localparam int SHIFT_VALUE = 28;
  localparam int SHIFT_DERIV = 14;

  typedef enum logic [1:0] {
    KIND_VALUE = 2'd0,
    KIND_DU    = 2'd1,
    KIND_DV    = 2'd2,
    KIND_NONE  = 2'd3
  } kind_t;

  typedef logic signed [NODE_W-1:0] node_t;
  typedef logic signed [WGT_W-1:0]  wgt_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [ACC_W-1:0]  acc_t;

  typedef node_t node_arr_t [NODES];
  typedef wgt_t  wgt_arr_t  [NODES];

  localparam acc_t RES_MAX = 64'sd2147483647;
  localparam acc_t RES_MIN = -64'sd2147483648;

endpackage

### hdl/qti_weight.sv
// First pipeline stage: basis weights for the requested kind, registered with the node values.
module qti_weight
  import qti_pkg::*;
(
  input  logic                      clk,
  input  logic                      en,
  input  kind_t                     kind,
  input  logic signed [COORD_W-1:0] coord_u,
  input  logic signed [COORD_W-1:0] coord_v,
  input  node_arr_t                 node_in,
  output wgt_arr_t                  wgt_r,
  output node_arr_t                 node_r,
  output kind_t                     kind_r
);

  localparam logic signed [EXT_W-1:0] ONE_EXT = EXT_W'(ONE_Q14);
  localparam wgt_t ONE_W = WGT_W'(ONE_Q14);

  logic signed [EXT_W-1:0] uu, vv, ww;
  logic signed [EXT_W:0]   tu, tv, tw;
  wgt_t                    eu, ev;
  logic signed [2*EXT_W:0] q0, q1, q2;
  wgt_t                    m3, m4, m5;
  wgt_arr_t                wgt_nxt;

  always_comb begin
    uu = EXT_W'(coord_u);
    vv = EXT_W'(coord_v);
    ww = ONE_EXT - uu - vv;
    // 2x - 1 for each coordinate, one bit wider.
    tu = ((EXT_W+1)'(uu) <<< 1) - (EXT_W+1)'(ONE_EXT);
    tv = ((EXT_W+1)'(vv) <<< 1) - (EXT_W+1)'(ONE_EXT);
    tw = ((EXT_W+1)'(ww) <<< 1) - (EXT_W+1)'(ONE_EXT);
    eu = WGT_W'(uu);
    ev = WGT_W'(vv);
    q0 = (2*EXT_W+1)'(ww) * (2*EXT_W+1)'(tw);
    q1 = (2*EXT_W+1)'(uu) * (2*EXT_W+1)'(tu);
    q2 = (2*EXT_W+1)'(vv) * (2*EXT_W+1)'(tv);
    m3 = WGT_W'(uu) * WGT_W'(ww);
    m4 = WGT_W'(uu) * WGT_W'(vv);
    m5 = WGT_W'(vv) * WGT_W'(ww);

    case (kind)
      KIND_VALUE: begin
        wgt_nxt[0] = WGT_W'(q0);
        wgt_nxt[1] = WGT_W'(q1);
        wgt_nxt[2] = WGT_W'(q2);
        wgt_nxt[3] = m3 <<< 2;
        wgt_nxt[4] = m4 <<< 2;
        wgt_nxt[5] = m5 <<< 2;
      end
      KIND_DU: begin
        wgt_nxt[0] = (eu <<< 2) + (ev <<< 2) - 3 * ONE_W;
        wgt_nxt[1] = (eu <<< 2) - ONE_W;
        wgt_nxt[2] = '0;
        wgt_nxt[3] = (ONE_W <<< 2) - (eu <<< 3) - (ev <<< 2);
        wgt_nxt[4] = ev <<< 2;
        wgt_nxt[5] = -(ev <<< 2);
      end
      KIND_DV: begin
        wgt_nxt[0] = (eu <<< 2) + (ev <<< 2) - 3 * ONE_W;
        wgt_nxt[1] = '0;
        wgt_nxt[2] = (ev <<< 2) - ONE_W;
        wgt_nxt[3] = -(eu <<< 2);
        wgt_nxt[4] = eu <<< 2;
        wgt_nxt[5] = (ONE_W <<< 2) - (eu <<< 2) - (ev <<< 3);
      end
      default: begin
        for (int i = 0; i < NODES; i++) wgt_nxt[i] = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      wgt_r  <= wgt_nxt;
      node_r <= node_in;
      kind_r <= kind;
    end
  end

endmodule

### hdl/qti_mac.sv
// Multiply stage and registered adder tree that form the exact weighted sum.
module qti_mac
  import qti_pkg::*;
(
  input  logic       clk,
  input  logic [3:0] en,
  input  wgt_arr_t   wgt,
  input  node_arr_t  node,
  input  kind_t      kind,
  output acc_t       acc_r,
  output kind_t      kind_r
);

  prod_t prod_r [NODES];
  acc_t  s01_r, s23_r, s45_r;
  acc_t  a_r, b_r;
  kind_t k2_r, k3_r, k4_r;

  // Stage 2: one product per node.
  always_ff @(posedge clk) begin
    if (en[0]) begin
      for (int i = 0; i < NODES; i++) prod_r[i] <= PROD_W'(node[i]) * PROD_W'(wgt[i]);
      k2_r <= kind;
    end
  end

  // Stage 3: pairwise sums.
  always_ff @(posedge clk) begin
    if (en[1]) begin
      s01_r <= ACC_W'(prod_r[0]) + ACC_W'(prod_r[1]);
      s23_r <= ACC_W'(prod_r[2]) + ACC_W'(prod_r[3]);
      s45_r <= ACC_W'(prod_r[4]) + ACC_W'(prod_r[5]);
      k3_r  <= k2_r;
    end
  end

  // Stage 4: second level of the tree.
  always_ff @(posedge clk) begin
    if (en[2]) begin
      a_r  <= s01_r + s23_r;
      b_r  <= s45_r;
      k4_r <= k3_r;
    end
  end

  // Stage 5: the full sum.
  always_ff @(posedge clk) begin
    if (en[3]) begin
      acc_r  <= a_r + b_r;
      kind_r <= k4_r;
    end
  end

endmodule

### hdl/qti_round.sv
// Final stage: round to nearest, clamp to 32 bits (zero for KIND_NONE) and register the result.
module qti_round
  import qti_pkg::*;
(
  input  logic                    clk,
  input  logic                    en,
  input  acc_t                    acc,
  input  kind_t                   kind,
  output logic signed [RES_W-1:0] result_r,
  output logic                    sat_r
);

  localparam acc_t HALF_VALUE = acc_t'(1) <<< (SHIFT_VALUE - 1);
  localparam acc_t HALF_DERIV = acc_t'(1) <<< (SHIFT_DERIV - 1);

  acc_t                    rnd;
  logic signed [RES_W-1:0] result_nxt;
  logic                    sat_nxt;

  always_comb begin
    // Adding half and shifting arithmetically gives halves toward plus infinity.
    if (kind == KIND_VALUE) begin
      rnd = (acc + HALF_VALUE) >>> SHIFT_VALUE;
    end else begin
      rnd = (acc + HALF_DERIV) >>> SHIFT_DERIV;
    end
    if (kind == KIND_NONE) begin
      result_nxt = '0;
      sat_nxt    = 1'b0;
    end else if (rnd > RES_MAX) begin
      result_nxt = RES_W'(RES_MAX);
      sat_nxt    = 1'b1;
    end else if (rnd < RES_MIN) begin
      result_nxt = RES_W'(RES_MIN);
      sat_nxt    = 1'b1;
    end else begin
      result_nxt = RES_W'(rnd);
      sat_nxt    = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      result_r <= result_nxt;
      sat_r    <= sat_nxt;
    end
  end

endmodule

### hdl/quad_triangle_interpolator_top.sv
// Top level of the quadratic six-node triangle interpolator pipeline.
//
// The block evaluates the quadratic six-node triangle basis at a point (u,v) given in signed
// Q2.14 and applies it to six 24-bit node values: kind 0 returns the interpolated value,
// kind 1 the derivative in u, kind 2 the derivative in v, and kind 3 returns zero. The weighted
// sum is formed exactly and rounded once to nearest (halves upward); results beyond the signed
// 32-bit range are clamped and flagged on out_saturated. One transfer is accepted in every
// cycle while in_stall is low, and each result passes through the six stages in order: the
// basis weight multipliers, the node-by-weight multipliers, two levels of the adder tree, the
// final add, and the rounding and clamping stage that also serves as the output register.
// A stall on the result side holds only the stages that are occupied; empty stages keep
// filling, so in_stall rises only when every stage holds an item.
module quad_triangle_interpolator_top
  import qti_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [1:0]                in_kind,
  input  logic signed [COORD_W-1:0] in_coord_u,
  input  logic signed [COORD_W-1:0] in_coord_v,
  input  logic signed [NODE_W-1:0]  in_node_value_0,
  input  logic signed [NODE_W-1:0]  in_node_value_1,
  input  logic signed [NODE_W-1:0]  in_node_value_2,
  input  logic signed [NODE_W-1:0]  in_node_value_3,
  input  logic signed [NODE_W-1:0]  in_node_value_4,
  input  logic signed [NODE_W-1:0]  in_node_value_5,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [RES_W-1:0]   out_result,
  output logic                      out_saturated
);

  localparam int STAGES = 6;

  // Valid bit and advance enable of each stage, index 1 is the first stage.
  logic [STAGES:1] valid_r;
  logic [STAGES:1] en;

  node_arr_t node_in;
  wgt_arr_t  wgt_s1;
  node_arr_t node_s1;
  kind_t     kind_s1;
  acc_t      acc_s5;
  kind_t     kind_s5;

  // A stage may load when it is empty or when the stage after it moves on.
  always_comb begin
    en[STAGES] = !valid_r[STAGES] || !out_stall;
    for (int k = STAGES - 1; k >= 1; k--) en[k] = !valid_r[k] || en[k+1];
  end

  assign in_stall = !en[1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      if (en[1]) valid_r[1] <= in_valid;
      for (int k = 2; k <= STAGES; k++) begin
        if (en[k]) valid_r[k] <= valid_r[k-1];
      end
    end
  end

  always_comb begin
    node_in[0] = in_node_value_0;
    node_in[1] = in_node_value_1;
    node_in[2] = in_node_value_2;
    node_in[3] = in_node_value_3;
    node_in[4] = in_node_value_4;
    node_in[5] = in_node_value_5;
  end

  qti_weight u_weight (
    .clk     (clk),
    .en      (en[1]),
    .kind    (kind_t'(in_kind)),
    .coord_u (in_coord_u),
    .coord_v (in_coord_v),
    .node_in (node_in),
    .wgt_r   (wgt_s1),
    .node_r  (node_s1),
    .kind_r  (kind_s1)
  );

  qti_mac u_mac (
    .clk    (clk),
    .en     (en[5:2]),
    .wgt    (wgt_s1),
    .node   (node_s1),
    .kind   (kind_s1),
    .acc_r  (acc_s5),
    .kind_r (kind_s5)
  );

  qti_round u_round (
    .clk      (clk),
    .en       (en[STAGES]),
    .acc      (acc_s5),
    .kind     (kind_s5),
    .result_r (out_result),
    .sat_r    (out_saturated)
  );

  assign out_valid = valid_r[STAGES];

  // The input side can only be held off when the whole pipeline is occupied.
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (&valid_r))
    else $error("input stalled while a pipeline stage was empty");

  // An accepted transfer always lands in the first stage.
  a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> valid_r[1])
    else $error("accepted transfer lost at the first stage");

  // A blocked stage 3 keeps its item.
  a_inner_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r[3] && !en[3]) |=> valid_r[3])
    else $error("blocked stage dropped its item");

  // A clamped result sits exactly on one of the two bounds.
  a_sat_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_saturated) |->
      (out_result == 32'sh7fffffff || out_result == 32'sh80000000))
    else $error("saturated flag set on a result inside the range");

endmodule
